// ===== hdl/drs_pkg.sv =====
// Shared types and constants for the distinct rank select block.
`timescale 1ns / 1ps

package drs_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned FUNC_W         = 2;
  localparam int unsigned IO_W           = 32;
  localparam int unsigned RANK_W         = 9;

  typedef enum logic [FUNC_W-1:0] {
    F_CLEAR  = 2'd0,
    F_INSERT = 2'd1,
    F_QUERY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_PROBE  = 2'd1,
    K_QUERY  = 2'd2
  } kind_t;

  typedef struct packed {
    logic              present;
    logic              live;
    kind_t             kind;
    logic [RANK_W-1:0] rank;
    logic              found;
  } tok_t;

endpackage

// ===== hdl/distinct_rank_select_top.sv =====
// Top level: command port, overflow flag and the chain of sorted value cells.
// A query result appears on done when its token leaves the last cell, for one cycle.
// Insert and query hold busy until their token leaves the last cell, walking the cell
// chain one cell per cycle, so no new beat is taken meanwhile; clear and unused codes
// do not raise busy.
// Reset: synchronous, empties the set and drops the overflow flag; no sweep follows.
// The receiver cannot stall: done is a one-cycle strobe.
`timescale 1ns / 1ps

module distinct_rank_select_top
  import drs_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [IO_W-1:0]   value_in,
  input  logic [RANK_W-1:0] rank,
  output logic              done,
  output logic [IO_W-1:0]   value_out,
  output logic              found,
  output logic              overflowed
);

  tok_t                  tok [CAPACITY+1];
  logic [VALUE_BITS-1:0] dat [CAPACITY+1];
  logic [CAPACITY-1:0]   vld;
  logic                  accept;
  logic                  clr;
  logic                  full;
  tok_t                  last;
  tok_t                  head_tok;
  logic [VALUE_BITS-1:0] head_dat;

  assign accept = start && !busy;
  assign clr    = accept && (func == F_CLEAR);
  assign full   = vld[CAPACITY-1];
  assign last   = tok[CAPACITY];
  assign tok[0] = head_tok;
  assign dat[0] = head_dat;

  always_comb begin
    head_tok.present = 1'b0;
    head_tok.live    = 1'b1;
    head_tok.kind    = full ? K_PROBE : K_INSERT;
    head_tok.rank    = rank;
    head_tok.found   = 1'b0;
    head_dat         = VALUE_BITS'(value_in);
    unique case (func) inside
      F_INSERT: begin
        head_tok.present = accept;
      end
      F_QUERY: begin
        head_tok.present = accept;
        head_tok.kind    = K_QUERY;
        head_dat         = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    drs_cell #(
      .VALUE_BITS(VALUE_BITS),
      .IDX       (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clr     (clr),
      .tok_in  (tok[i]),
      .data_in (dat[i]),
      .tok_out (tok[i+1]),
      .data_out(dat[i+1]),
      .vld     (vld[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      overflowed <= 1'b0;
    end else begin
      if (accept) begin
        unique case (func) inside
          F_CLEAR:           overflowed <= 1'b0;
          F_INSERT, F_QUERY: busy       <= 1'b1;
          default: begin
          end
        endcase
      end
      if (last.present) begin
        busy <= 1'b0;
        if ((last.kind == K_PROBE) && last.live) begin
          overflowed <= 1'b1;
        end
      end
    end
  end

  assign done      = last.present && (last.kind == K_QUERY);
  assign found     = last.found;
  assign value_out = last.found ? IO_W'(dat[CAPACITY]) : '0;

endmodule

// ===== hdl/drs_cell.sv =====
// One compare-and-shift cell of the sorted value chain.
`timescale 1ns / 1ps

module drs_cell
  import drs_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clr,
  input  tok_t                  tok_in,
  input  logic [VALUE_BITS-1:0] data_in,
  output tok_t                  tok_out,
  output logic [VALUE_BITS-1:0] data_out,
  output logic                  vld
);

  localparam logic [31:0] POS = 32'(IDX + 1);

  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] val_next;
  logic                  vld_next;
  tok_t                  tok_next;
  logic [VALUE_BITS-1:0] data_next;
  logic                  rank_hit;

  assign rank_hit = (32'(tok_in.rank) == POS);

  always_comb begin
    val_next  = val;
    vld_next  = vld;
    tok_next  = tok_in;
    data_next = data_in;
    if (clr) begin
      vld_next = 1'b0;
    end
    if (tok_in.present && tok_in.live) begin
      case (tok_in.kind)
        K_INSERT: begin
          if (!vld) begin
            val_next      = data_in;
            vld_next      = 1'b1;
            tok_next.live = 1'b0;
          end else if (val == data_in) begin
            tok_next.live = 1'b0;
          end else if (val > data_in) begin
            val_next  = data_in;
            data_next = val;
          end
        end
        K_PROBE: begin
          if (vld && (val == data_in)) begin
            tok_next.live = 1'b0;
          end
        end
        K_QUERY: begin
          if (rank_hit) begin
            tok_next.live = 1'b0;
            if (vld) begin
              tok_next.found = 1'b1;
              data_next      = val;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val      <= val_next;
    data_out <= data_next;
    if (rst) begin
      vld     <= 1'b0;
      tok_out <= '0;
    end else begin
      vld     <= vld_next;
      tok_out <= tok_next;
    end
  end

endmodule

// ===== hdl/drs_checker.sv =====
// Port-level checks for the distinct rank select block, bound to the top level.
`timescale 1ns / 1ps

module drs_checker
  import drs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [FUNC_W-1:0] func,
  input logic              done,
  input logic [IO_W-1:0]   value_out,
  input logic              found,
  input logic              overflowed
);

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result beat outside a busy window");

  a_done_releases: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("busy or strobe held after result beat");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (value_out == '0))
    else $error("nonzero value on a miss");

  a_work_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ((func == F_INSERT) || (func == F_QUERY))) |=> busy)
    else $error("insert or query beat did not raise busy");

  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    (overflowed && !(start && !busy && (func == F_CLEAR))) |=> overflowed)
    else $error("overflow flag dropped without a clear");

endmodule

bind distinct_rank_select_top drs_checker u_drs_checker (.*);
